@@ src/gmdw_pkg.sv @@
// Package for the grid maze walker: request and result types, codes and sizes.
// Depends on nothing; used by the top level grid_maze_dfs_walker.
`default_nettype none
package gmdw_pkg;
  localparam int GridRows   = 16;
  localparam int GridCols   = 32;
  localparam int StackDepth = 512;
  localparam int CellAw     = 9;
  localparam int StackAw    = 9;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_BEGIN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_ADVANCE = 2'd0,
    ST_BACK    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_STUCK   = 2'd3
  } status_t;

  localparam logic [1:0] CELL_OPEN = 2'd0;
  localparam logic [1:0] CELL_WALL = 2'd1;
  localparam logic [1:0] CELL_SEEN = 2'd2;

  localparam logic [1:0] CFG_START_ROW = 2'd0;
  localparam logic [1:0] CFG_START_COL = 2'd1;
  localparam logic [1:0] CFG_GOAL_ROW  = 2'd2;
  localparam logic [1:0] CFG_GOAL_COL  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] cell_row;
    logic [4:0] cell_col;
    logic       is_wall;
    logic [8:0] path_index;
  } in_req_t;

  typedef struct packed {
    logic [3:0] walker_row_out;
    logic [4:0] walker_col_out;
    logic [1:0] search_state;
    logic [1:0] move_code;
    logic       move_valid;
    logic [9:0] path_length;
  } out_res_t;
endpackage
`default_nettype wire

@@ src/gmdw_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module gmdw_ram #(
  parameter int Width = 2,
  parameter int Depth = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/grid_maze_dfs_walker.sv @@
// Top level of the grid maze walker: sequencer around three RAMs (grid,
// path stack, junction stack). Uses gmdw_pkg and gmdw_ram.
//
// Usage: write the grid with write-cell requests, set start and goal through
// the cfg_ port, issue a begin-search request, then step requests. Every
// request on the in_ channel yields exactly one result on the out_ channel.
// A write-cell or begin-search request, or a step after the search has
// ended, goes straight to its result; a path read first reads the path
// stack; a step while backtracking reads the path and junction stacks, then
// pops; a step while advancing makes the four neighbour reads one at a time
// through the single read port of the grid RAM, each as a request state and
// a data state; a dead end found while advancing also pops in the same step.
// One request is in work at a time, so a new request is accepted the cycle
// after the result is loaded. in_stall is high from acceptance until the
// result has been loaded into the output register. The result register
// holds while out_stall is high, and a new request may be accepted while it
// waits; a second result then holds the sequencer in its last state until
// the first is taken.
// Reset clears the walker, stacks counts, status and configuration to their
// defaults; the grid and stack memories are left undefined until written.
// Configuration must only be written while the block is idle.
`default_nettype none
module grid_maze_dfs_walker
  import gmdw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_wdata
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NREQ  = 8'b0000_0010,
    S_NDATA = 8'b0000_0100,
    S_PREAD = 8'b0000_1000,
    S_DEC   = 8'b0001_0000,
    S_JRD   = 8'b0010_0000,
    S_POP   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } fsm_t;

  fsm_t        st_r, st_nxt;
  in_req_t     req_r;
  logic [3:0]  srow_r, grow_r, wrow_r;
  logic [4:0]  scol_r, gcol_r, wcol_r;
  logic [1:0]  phase_r, status_r;
  logic [9:0]  pcnt_r, jcnt_r;
  logic [1:0]  dir_r;
  logic [3:0]  open_r;
  logic        goal_r;
  logic [1:0]  m_r;
  logic        mv_r;

  // Memory ports.
  logic             g_we, p_we, j_we;
  logic [CellAw-1:0] g_wa, g_ra;
  logic [1:0]       g_wd, g_rd, p_wd, p_rd;
  logic [StackAw-1:0] p_wa, p_ra, j_wa, j_ra;
  logic [8:0]       j_wd, j_rd;

  gmdw_ram #(.Width(2), .Depth(GridRows*GridCols)) u_grid (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  gmdw_ram #(.Width(2), .Depth(StackDepth)) u_path (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  gmdw_ram #(.Width(9), .Depth(StackDepth)) u_junc (
    .clk, .we(j_we), .waddr(j_wa), .wdata(j_wd), .raddr(j_ra), .rdata(j_rd));

  // Neighbour in direction dir_r of the walker; nb_ok false outside the grid.
  logic [4:0] nb_row;
  logic [5:0] nb_col;
  logic       nb_ok, nb_goal;
  always_comb begin
    nb_row = {1'b0, wrow_r};
    nb_col = {1'b0, wcol_r};
    nb_ok  = 1'b1;
    unique case (dir_r)
      2'd0: nb_row = {1'b0, wrow_r} + 5'd1;
      2'd1: begin nb_ok = (wrow_r != 4'd0); nb_row = {1'b0, wrow_r} - 5'd1; end
      2'd2: nb_col = {1'b0, wcol_r} + 6'd1;
      default: begin nb_ok = (wcol_r != 5'd0); nb_col = {1'b0, wcol_r} - 6'd1; end
    endcase
    if (nb_row >= 5'(GridRows) || nb_col >= 6'(GridCols)) nb_ok = 1'b0;
    nb_goal = nb_ok && (nb_row[3:0] == grow_r) && (nb_col[4:0] == gcol_r);
  end

  // Chosen direction: first open way from the phase, cyclically.
  logic [1:0] pick;
  logic       any_open, two_open;
  logic [2:0] nopen;
  always_comb begin
    pick = 2'd0;
    any_open = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      if (open_r[2'(phase_r + 2'(k))]) begin
        pick = 2'(phase_r + 2'(k));
        any_open = 1'b1;
      end
    end
    nopen = 3'(open_r[0]) + 3'(open_r[1]) + 3'(open_r[2]) + 3'(open_r[3]);
    two_open = (nopen >= 3'd2);
  end

  // Target of moving in pick.
  logic [3:0] mv_row;
  logic [4:0] mv_col;
  always_comb begin
    mv_row = wrow_r;
    mv_col = wcol_r;
    unique case (pick)
      2'd0: mv_row = wrow_r + 4'd1;
      2'd1: mv_row = wrow_r - 4'd1;
      2'd2: mv_col = wcol_r + 5'd1;
      default: mv_col = wcol_r - 5'd1;
    endcase
  end

  // Undo of the popped move.
  logic [3:0] pp_row;
  logic [4:0] pp_col;
  always_comb begin
    pp_row = wrow_r;
    pp_col = wcol_r;
    unique case (p_rd)
      2'd0: pp_row = wrow_r - 4'd1;
      2'd1: pp_row = wrow_r + 4'd1;
      2'd2: pp_col = wcol_r - 5'd1;
      default: pp_col = wcol_r + 5'd1;
    endcase
  end

  logic accept, out_take, start_ok, wr_ok, res_load;
  assign in_stall = (st_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  // The result register is free unless it holds a result that is being stalled.
  assign res_load = (st_r == S_DONE) && !(out_valid && out_stall);
  assign start_ok = ({1'b0, srow_r} < 5'(GridRows)) && ({1'b0, scol_r} < 6'(GridCols));
  assign wr_ok    = ({1'b0, in_data.cell_row} < 5'(GridRows)) &&
                    ({1'b0, in_data.cell_col} < 6'(GridCols));

  // Memory control.
  always_comb begin
    g_we = 1'b0; g_wa = {in_data.cell_row, in_data.cell_col};
    g_wd = in_data.is_wall ? CELL_WALL : CELL_OPEN;
    g_ra = {nb_row[3:0], nb_col[4:0]};
    p_we = 1'b0; p_wa = pcnt_r[StackAw-1:0]; p_wd = pick;
    p_ra = (st_r == S_IDLE) ? in_data.path_index : 9'(pcnt_r - 10'd1);
    j_we = 1'b0; j_wa = jcnt_r[StackAw-1:0]; j_wd = {wrow_r, wcol_r};
    j_ra = 9'(jcnt_r - 10'd1);
    if (accept && in_data.kind == KIND_WRITE && wr_ok) begin
      g_we = 1'b1;
    end else if (accept && in_data.kind == KIND_BEGIN && start_ok) begin
      g_we = 1'b1; g_wa = {srow_r, scol_r}; g_wd = CELL_SEEN;
    end else if (st_r == S_DEC && !goal_r && any_open && pcnt_r < 10'(StackDepth)) begin
      g_we = 1'b1; g_wa = {mv_row, mv_col}; g_wd = CELL_SEEN;
      p_we = 1'b1;
      j_we = two_open && (jcnt_r < 10'(StackDepth));
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (accept) begin
        unique case (kind_t'(in_data.kind))
          KIND_STEP:  st_nxt = (status_r == ST_ADVANCE) ? S_NREQ :
                               (status_r == ST_BACK) ? S_PREAD : S_DONE;
          KIND_READ:  st_nxt = S_PREAD;
          default:    st_nxt = S_DONE;
        endcase
      end
      S_NREQ:  st_nxt = S_NDATA;
      S_NDATA: st_nxt = (dir_r == 2'd3) ? S_DEC : S_NREQ;
      S_PREAD: st_nxt = (req_r.kind == KIND_READ || pcnt_r == 10'd0) ? S_DONE : S_JRD;
      S_DEC:   st_nxt = (!goal_r && !any_open && jcnt_r != 10'd0) ? S_PREAD : S_DONE;
      S_JRD:   st_nxt = S_POP;
      S_POP:   st_nxt = S_DONE;
      S_DONE:  st_nxt = res_load ? S_IDLE : S_DONE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      srow_r <= 4'd1; scol_r <= 5'd1; grow_r <= 4'd1; gcol_r <= 5'd2;
      wrow_r <= '0; wcol_r <= '0; phase_r <= '0; status_r <= ST_ADVANCE;
      pcnt_r <= '0; jcnt_r <= '0; out_valid <= 1'b0;
      dir_r <= '0; open_r <= '0; goal_r <= 1'b0; m_r <= '0; mv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_ROW: srow_r <= cfg_wdata[3:0];
          CFG_START_COL: scol_r <= cfg_wdata;
          CFG_GOAL_ROW:  grow_r <= cfg_wdata[3:0];
          default:       gcol_r <= cfg_wdata;
        endcase
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (accept) begin
          req_r <= in_data;
          m_r <= '0; mv_r <= 1'b0; dir_r <= '0; open_r <= '0; goal_r <= 1'b0;
          if (in_data.kind == KIND_BEGIN) begin
            wrow_r <= srow_r; wcol_r <= scol_r; phase_r <= '0;
            pcnt_r <= '0; jcnt_r <= '0; status_r <= ST_ADVANCE;
          end
        end
        S_NDATA: begin
          open_r[dir_r] <= nb_ok && !nb_goal && (g_rd == CELL_OPEN);
          if (nb_goal) goal_r <= 1'b1;
          dir_r <= dir_r + 2'd1;
        end
        S_DEC: begin
          if (goal_r) status_r <= ST_FOUND;
          else if (!any_open) begin
            if (jcnt_r == 10'd0) status_r <= ST_STUCK;
          end else if (pcnt_r >= 10'(StackDepth)) status_r <= ST_STUCK;
          else begin
            if (two_open && jcnt_r < 10'(StackDepth)) jcnt_r <= jcnt_r + 10'd1;
            wrow_r <= mv_row; wcol_r <= mv_col;
            pcnt_r <= pcnt_r + 10'd1; phase_r <= pick;
            m_r <= pick; mv_r <= 1'b1;
          end
        end
        S_PREAD: if (req_r.kind == KIND_READ) begin
          if ({1'b0, req_r.path_index} < pcnt_r) begin
            m_r <= p_rd; mv_r <= 1'b1;
          end
        end else if (pcnt_r == 10'd0) begin
          status_r <= ST_STUCK;
        end
        S_POP: begin
          pcnt_r <= pcnt_r - 10'd1;
          wrow_r <= pp_row; wcol_r <= pp_col;
          m_r <= p_rd; mv_r <= 1'b1;
          status_r <= ST_BACK;
          if (jcnt_r != 10'd0 && pp_row == j_rd[8:5] && pp_col == j_rd[4:0]) begin
            jcnt_r <= jcnt_r - 10'd1; phase_r <= '0; status_r <= ST_ADVANCE;
          end
        end
        S_DONE: if (res_load) begin
          out_data.walker_row_out <= wrow_r;
          out_data.walker_col_out <= wcol_r;
          out_data.search_state   <= status_r;
          out_data.move_code      <= m_r;
          out_data.move_valid     <= mv_r;
          out_data.path_length    <= pcnt_r;
        end
        default: ;
      endcase
    end
  end

  // A pop only happens with at least one move on the path stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_POP) |-> (pcnt_r != 10'd0)) else $error("pop from empty path");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("request accepted while busy");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r <= 10'(StackDepth)) && (jcnt_r <= 10'(StackDepth)))
    else $error("stack count out of range");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire
